// ===== design/affine_point_transform_clip_macros.svh =====
// Assertion helpers for the affine point transform block.
// Every check runs on the rising edge of clk_i and is off while rst_ni is low.
`ifndef AFFINE_POINT_TRANSFORM_CLIP_MACROS_SVH
`define AFFINE_POINT_TRANSFORM_CLIP_MACROS_SVH

// Same-cycle implication.
`define APTC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aptc check failed");

// Next-cycle implication.
`define APTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aptc check failed");

`endif

// ===== design/aptc_pkg.sv =====
package aptc_pkg;

  localparam int unsigned PointW = 16;
  localparam int unsigned CoefW  = 24;
  localparam int unsigned ShiftW = 24;
  localparam int unsigned ClipW  = 14;
  localparam int unsigned FracW  = 16;
  localparam int unsigned CfgW   = 2 * CoefW;
  localparam int unsigned ProdW  = CoefW + PointW;
  localparam int unsigned SumW   = ProdW + 3;
  localparam int unsigned IntW   = SumW - FracW;

  // 1.0 in Q8.16
  localparam logic signed [CoefW-1:0] CoefOne = CoefW'(1 << FracW);
  localparam int unsigned FracHalf = 1 << (FracW - 1);

  typedef enum logic [2:0] {
    REG_KIND        = 3'd0,
    REG_COEF_ROW0   = 3'd1,
    REG_COEF_ROW1   = 3'd2,
    REG_SHIFT_X     = 3'd3,
    REG_SHIFT_Y     = 3'd4,
    REG_CLIP_WIDTH  = 3'd5,
    REG_CLIP_HEIGHT = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [ClipW-1:0] coord;
    logic             clipped;
  } clamp_t;

endpackage

// ===== design/aptc_in_if.sv =====
interface aptc_in_if;
  import aptc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [PointW-1:0] point_x;
  logic signed [PointW-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// ===== design/aptc_out_if.sv =====
interface aptc_out_if;
  import aptc_pkg::*;

  logic             valid;
  logic             ready;
  logic [ClipW-1:0] out_x;
  logic [ClipW-1:0] out_y;
  logic             was_clipped;
  logic             size_error;

  modport source (output valid, output out_x, output out_y, output was_clipped,
                  output size_error, input ready);
  modport sink   (input valid, input out_x, input out_y, input was_clipped,
                  input size_error, output ready);
endinterface

// ===== design/affine_point_transform_clip.sv =====
// Affine point transform with clipping. Each word on point_i is a signed
// integer point; the block maps it through either a pure translation
// (transform_kind 0) or a full 2x2 matrix plus translation (transform_kind 1,
// coefficients Q8.16, translation Q16.8), rounds each coordinate half away
// from zero and clamps it to 0..clip_width / 0..clip_height, flagging
// was_clipped. With both clip sizes zero the result is zero with size_error.
// Timing: a three-stage pipeline (multiply, sum, round/clamp into the output
// register). A point passes through the product, sum and output registers in
// turn before its result is valid on result_o, and one point per cycle is
// accepted as long as result_o is drained. Each stage moves forward whenever
// the stage after it is empty or moving, so holes in the pipe are filled
// while a finished word waits on result_o.
// Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_data_i);
// write it only while no point is in flight. Unknown indexes are ignored.
`include "affine_point_transform_clip_macros.svh"

module affine_point_transform_clip
  import aptc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i,
  aptc_in_if.sink         point_i,
  aptc_out_if.source      result_o
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic              kind_q;
  logic [CfgW-1:0]   coef_row0_q, coef_row1_q;
  logic [ShiftW-1:0] shift_x_q, shift_y_q;
  logic [ClipW-1:0]  clip_width_q, clip_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q        <= 1'b0;
      coef_row0_q   <= CfgW'({CoefW'(0), CoefOne});
      coef_row1_q   <= CfgW'({CoefOne, CoefW'(0)});
      shift_x_q     <= '0;
      shift_y_q     <= '0;
      clip_width_q  <= '0;
      clip_height_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_KIND:        kind_q        <= cfg_data_i[0];
        REG_COEF_ROW0:   coef_row0_q   <= cfg_data_i;
        REG_COEF_ROW1:   coef_row1_q   <= cfg_data_i;
        REG_SHIFT_X:     shift_x_q     <= cfg_data_i[ShiftW-1:0];
        REG_SHIFT_Y:     shift_y_q     <= cfg_data_i[ShiftW-1:0];
        REG_CLIP_WIDTH:  clip_width_q  <= cfg_data_i[ClipW-1:0];
        REG_CLIP_HEIGHT: clip_height_q <= cfg_data_i[ClipW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  logic in_fire;

  assign en3 = !v3_q || result_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign point_i.ready = en1;
  assign in_fire = point_i.valid && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= point_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: coefficient select and the four products
  // ---------------------------------------------------------------------
  logic signed [CoefW-1:0] a00, a01, a10, a11;
  logic signed [ProdW-1:0] p00_d, p01_d, p10_d, p11_d;
  logic signed [ProdW-1:0] p00_q, p01_q, p10_q, p11_q;

  // Offset mode runs through the identity matrix.
  always_comb begin
    if (kind_q) begin
      a00 = coef_row0_q[CoefW-1:0];
      a01 = coef_row0_q[CfgW-1:CoefW];
      a10 = coef_row1_q[CoefW-1:0];
      a11 = coef_row1_q[CfgW-1:CoefW];
    end else begin
      a00 = CoefOne;
      a01 = '0;
      a10 = '0;
      a11 = CoefOne;
    end
  end

  assign p00_d = a00 * point_i.point_x;
  assign p01_d = a01 * point_i.point_y;
  assign p10_d = a10 * point_i.point_x;
  assign p11_d = a11 * point_i.point_y;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      p00_q <= p00_d;
      p01_q <= p01_d;
      p10_q <= p10_d;
      p11_q <= p11_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: sums with the translation lined up to 16 fraction bits
  // ---------------------------------------------------------------------
  logic signed [ShiftW+7:0] tx_scaled, ty_scaled;
  logic signed [SumW-1:0]   sum_x_d, sum_y_d, sum_x_q, sum_y_q;

  assign tx_scaled = {shift_x_q, 8'h00};
  assign ty_scaled = {shift_y_q, 8'h00};
  assign sum_x_d   = SumW'(p00_q) + SumW'(p01_q) + SumW'(tx_scaled);
  assign sum_y_d   = SumW'(p10_q) + SumW'(p11_q) + SumW'(ty_scaled);

  always_ff @(posedge clk_i) begin
    if (en2) begin
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: round half away from zero, clamp, output register
  // ---------------------------------------------------------------------
  // Negative values get a bias one short of a half, so the floor of the
  // shift lands on the rounded-away integer.
  function automatic clamp_t round_clamp(logic [SumW-1:0] sum, logic [ClipW-1:0] limit);
    logic [SumW-1:0] biased;
    logic [IntW-1:0] whole;
    clamp_t          res;
    biased = sum + (sum[SumW-1] ? SumW'(FracHalf - 1) : SumW'(FracHalf));
    whole  = biased[SumW-1:FracW];
    if (whole[IntW-1]) begin
      res.coord   = '0;
      res.clipped = 1'b1;
    end else if (whole[IntW-2:0] > (IntW-1)'(limit)) begin
      res.coord   = limit;
      res.clipped = 1'b1;
    end else begin
      res.coord   = whole[ClipW-1:0];
      res.clipped = 1'b0;
    end
    return res;
  endfunction

  clamp_t           cx, cy;
  logic             size_err;
  logic [ClipW-1:0] out_x_q, out_y_q;
  logic             clipped_q, size_err_q;

  assign cx       = round_clamp(sum_x_q, clip_width_q);
  assign cy       = round_clamp(sum_y_q, clip_height_q);
  assign size_err = (clip_width_q == '0) && (clip_height_q == '0);

  always_ff @(posedge clk_i) begin
    if (en3) begin
      if (size_err) begin
        out_x_q   <= '0;
        out_y_q   <= '0;
        clipped_q <= 1'b0;
      end else begin
        out_x_q   <= cx.coord;
        out_y_q   <= cy.coord;
        clipped_q <= cx.clipped || cy.clipped;
      end
      size_err_q <= size_err;
    end
  end

  assign result_o.valid       = v3_q;
  assign result_o.out_x       = out_x_q;
  assign result_o.out_y       = out_y_q;
  assign result_o.was_clipped = clipped_q;
  assign result_o.size_error  = size_err_q;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `APTC_ASSERT_NOW(a_err_zero, v3_q && size_err_q, out_x_q == '0 && out_y_q == '0 && !clipped_q)
  `APTC_ASSERT_NOW(a_in_bounds, v3_q && !size_err_q,
                   out_x_q <= clip_width_q && out_y_q <= clip_height_q)
  `APTC_ASSERT_NEXT(a_take_lands, in_fire, v1_q)
  `APTC_ASSERT_NEXT(a_stage2_holds, v2_q && !en3, v2_q && $stable(sum_x_q) && $stable(sum_y_q))

endmodule

// ===== tb/sv/affine_point_transform_clip_tb.sv =====
`timescale 1ns / 1ps

module affine_point_transform_clip_tb;
  import aptc_pkg::*;

  // Index 7 is not mapped; a write there must leave every register alone.
  localparam logic [2:0] RegNone = 3'd7;

  localparam int unsigned RandItems  = 1630;
  localparam int unsigned CycleLimit = 800000;
  // Pipe is three stages deep; extra edges after the last drain catch stray words.
  localparam int unsigned TailCycles = 8;
  localparam int unsigned MaxReports = 10;

  typedef enum logic {
    STEP_WRITE,
    STEP_POINT
  } step_kind_e;

  // One expected output word.
  typedef struct packed {
    logic [ClipW-1:0] x;
    logic [ClipW-1:0] y;
    logic             clipped;
    logic             size_err;
  } mapped_pt_t;

  // Directed plan entry: either a register write or a point. A point with
  // fixed set carries its expected word; otherwise the predictor supplies it.
  typedef struct {
    step_kind_e               kind;
    logic [2:0]               idx;
    logic [CfgW-1:0]          data;
    logic signed [PointW-1:0] px;
    logic signed [PointW-1:0] py;
    bit                       fixed;
    mapped_pt_t               want;
  } plan_step_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [2:0]      cfg_index_i;
  logic [CfgW-1:0] cfg_data_i;

  aptc_in_if  point_if ();
  aptc_out_if result_if ();

  affine_point_transform_clip u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .point_i     (point_if),
    .result_o    (result_if)
  );

  // Shadow copy of the register file, kept in step with every write.
  logic                     kind_r;
  logic [CfgW-1:0]          row0_r;
  logic [CfgW-1:0]          row1_r;
  logic signed [ShiftW-1:0] shx_r;
  logic signed [ShiftW-1:0] shy_r;
  logic [ClipW-1:0]         cw_r;
  logic [ClipW-1:0]         ch_r;

  mapped_pt_t  pending_q[$];   // expected words, oldest first
  plan_step_t  plan_q[$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  bit          calm        = 1'b0;  // no idling on either side this phase

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void shadow_reset();
    kind_r = 1'b0;
    row0_r = CfgW'(CoefOne);                    // a00 = 1.0, a01 = 0
    row1_r = {CoefOne, {CoefW{1'b0}}};          // a10 = 0,   a11 = 1.0
    shx_r  = '0;
    shy_r  = '0;
    cw_r   = '0;
    ch_r   = '0;
  endfunction

  // Bits above a register's width are dropped, unmapped indexes ignored.
  function automatic void shadow_write(logic [2:0] idx, logic [CfgW-1:0] d);
    case (idx)
      REG_KIND:        kind_r = d[0];
      REG_COEF_ROW0:   row0_r = d;
      REG_COEF_ROW1:   row1_r = d;
      REG_SHIFT_X:     shx_r  = d[ShiftW-1:0];
      REG_SHIFT_Y:     shy_r  = d[ShiftW-1:0];
      REG_CLIP_WIDTH:  cw_r   = d[ClipW-1:0];
      REG_CLIP_HEIGHT: ch_r   = d[ClipW-1:0];
      default: ;
    endcase
  endfunction

  // Drop FracW fraction bits, halves going away from zero.
  function automatic longint round_away(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + longint'(FracHalf)) >>> FracW;
    return (v < 0) ? -m : m;
  endfunction

  function automatic clamp_t clamp_to(longint v, logic [ClipW-1:0] lim);
    clamp_t c;
    c.clipped = 1'b0;
    if (v < 0) begin
      c.coord   = '0;
      c.clipped = 1'b1;
    end else if (v > longint'(lim)) begin
      c.coord   = lim;
      c.clipped = 1'b1;
    end else begin
      c.coord = v[ClipW-1:0];
    end
    return c;
  endfunction

  function automatic mapped_pt_t map_point(logic signed [PointW-1:0] px,
                                           logic signed [PointW-1:0] py);
    longint     a00, a01, a10, a11, tx, ty;
    clamp_t     cx, cy;
    mapped_pt_t r;
    r = '0;
    if (cw_r == '0 && ch_r == '0) begin
      r.size_err = 1'b1;
      return r;
    end
    // Offset mode uses the identity matrix whatever the coefficients hold.
    a00 = longint'(CoefOne);
    a01 = 0;
    a10 = 0;
    a11 = longint'(CoefOne);
    if (kind_r) begin
      a00 = longint'($signed(row0_r[CoefW-1:0]));
      a01 = longint'($signed(row0_r[CfgW-1:CoefW]));
      a10 = longint'($signed(row1_r[CoefW-1:0]));
      a11 = longint'($signed(row1_r[CfgW-1:CoefW]));
    end
    // Q16.8 shift brought to 16 fraction bits.
    tx = longint'(shx_r) * 256;
    ty = longint'(shy_r) * 256;
    cx = clamp_to(round_away(a00 * longint'(px) + a01 * longint'(py) + tx), cw_r);
    cy = clamp_to(round_away(a10 * longint'(px) + a11 * longint'(py) + ty), ch_r);
    r.x       = cx.coord;
    r.y       = cy.coord;
    r.clipped = cx.clipped | cy.clipped;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------

  // Mostly back to back, sometimes a short pause, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sometimes fill the unused upper bits of a write with noise.
  function automatic logic [CfgW-1:0] with_junk(logic [CfgW-1:0] v, int unsigned w);
    logic [CfgW-1:0] noise;
    noise = CfgW'({$urandom(), $urandom()});
    if ($urandom_range(0, 3) == 0) begin
      for (int i = w; i < CfgW; i++) v[i] = noise[i];
    end
    return v;
  endfunction

  function automatic logic [CoefW-1:0] pick_coef();
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return CoefW'($urandom());
      3: return CoefOne;
      4: return '0;
      default: return CoefW'(int'($urandom_range(0, 262144)) - 131072);  // +-2.0
    endcase
  endfunction

  function automatic logic [ShiftW-1:0] pick_shift();
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return ShiftW'($urandom());
      3: return '0;
      default: return ShiftW'(int'($urandom_range(0, 2097152)) - 1048576);
    endcase
  endfunction

  function automatic logic [ClipW-1:0] pick_clip();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return ClipW'(1);
      default: return ClipW'($urandom_range(1, 16383));
    endcase
  endfunction

  // Most points land around the target image, the rest anywhere.
  function automatic logic signed [PointW-1:0] pick_coord(logic [ClipW-1:0] lim);
    if ($urandom_range(0, 9) < 7)
      return PointW'(int'($urandom_range(0, int'(lim) + 128)) - 64);
    return PointW'($urandom());
  endfunction

  // ---------------------------------------------------------------------------
  // Directed plan
  // ---------------------------------------------------------------------------

  function automatic mapped_pt_t want(int x, int y, bit c, bit e);
    mapped_pt_t w;
    w.x        = ClipW'(x);
    w.y        = ClipW'(y);
    w.clipped  = c;
    w.size_err = e;
    return w;
  endfunction

  function automatic void plan_write(logic [2:0] idx, logic [CfgW-1:0] d);
    plan_step_t s;
    s       = '{kind: STEP_WRITE, default: '0};
    s.idx   = idx;
    s.data  = d;
    plan_q.insert(plan_q.size(), s);
  endfunction

  function automatic void plan_point(logic signed [PointW-1:0] px,
                                     logic signed [PointW-1:0] py,
                                     bit fixed, mapped_pt_t w);
    plan_step_t s;
    s       = '{kind: STEP_POINT, default: '0};
    s.px    = px;
    s.py    = py;
    s.fixed = fixed;
    s.want  = w;
    plan_q.insert(plan_q.size(), s);
  endfunction

  function automatic void build_plan();
    // Out of reset both clip sizes are zero: every point is a size error.
    plan_point(32767, -32768, 1'b1, want(0, 0, 0, 1));
    plan_point(0, 0, 1'b1, want(0, 0, 0, 1));
    // Only the height is zero: y clamps to 0 like any other overrun.
    plan_write(REG_CLIP_WIDTH, 48'd16383);
    plan_point(5, 5, 1'b1, want(5, 0, 1, 0));
    // Height written with noise above bit 13; only the low bits count.
    plan_write(REG_CLIP_HEIGHT, 48'hFFFF_FFFF_FFFF);
    plan_point(0, 0, 1'b1, want(0, 0, 0, 0));
    plan_point(16383, 16383, 1'b1, want(16383, 16383, 0, 0));
    plan_point(32767, 32767, 1'b1, want(16383, 16383, 1, 0));
    plan_point(-32768, -1, 1'b1, want(0, 0, 1, 0));
    // Half-pixel offsets in offset mode, shift_x with junk in the upper bits.
    plan_write(REG_SHIFT_X, 48'hABCDEF_000080);   // +0.5
    plan_write(REG_SHIFT_Y, 48'h000000_FFFF80);   // -0.5
    plan_point(10, 10, 1'b0, '0);
    plan_point(0, 0, 1'b0, '0);
    plan_point(-1, 3, 1'b0, '0);
    // Unmapped index: nothing may change.
    plan_write(RegNone, 48'hFFFF_FFFF_FFFF);
    plan_point(100, 200, 1'b0, '0);
    // Affine mode with every coefficient and shift at an extreme.
    plan_write(REG_KIND, 48'd1);
    plan_write(REG_COEF_ROW0, 48'h800000_7FFFFF);
    plan_write(REG_COEF_ROW1, 48'h7FFFFF_800000);
    plan_write(REG_SHIFT_X, 48'h000000_7FFFFF);
    plan_write(REG_SHIFT_Y, 48'h000000_800000);
    plan_point(32767, -32768, 1'b0, '0);
    plan_point(-32768, 32767, 1'b0, '0);
    plan_point(32767, 32767, 1'b0, '0);
    plan_point(-32768, -32768, 1'b0, '0);
    plan_point(1, -1, 1'b0, '0);
    // Half scale: odd inputs land exactly on .5.
    plan_write(REG_COEF_ROW0, 48'h000000_008000);
    plan_write(REG_COEF_ROW1, 48'h008000_000000);
    plan_write(REG_SHIFT_X, 48'd0);
    plan_write(REG_SHIFT_Y, 48'd0);
    plan_point(3, 3, 1'b0, '0);
    plan_point(5, -7, 1'b0, '0);
    // Back to offset mode; bit 0 clear, upper bits set.
    plan_write(REG_KIND, 48'hFFFF_FFFF_FFFE);
    plan_point(7, 9, 1'b0, '0);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  function automatic void log_fail(string msg);
    fail_count++;
    if (fail_count <= MaxReports) $display("%s", msg);
  endfunction

  // Write enable is left high so back-to-back writes need no extra edge;
  // the next point lowers it.
  task automatic reg_write(logic [2:0] idx, logic [CfgW-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    shadow_write(idx, d);
  endtask

  // Sender holds off until every expected word has come back.
  task automatic drain();
    point_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Valid stays high after the word is taken, so the caller must either send
  // another word or drain.
  task automatic send_point(logic signed [PointW-1:0] px, logic signed [PointW-1:0] py,
                            bit fixed, mapped_pt_t w);
    int unsigned gap;
    gap = calm ? 0 : idle_len();
    if (cfg_we_i) cfg_we_i <= 1'b0;
    if (gap != 0) begin
      point_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    point_if.valid   <= 1'b1;
    point_if.point_x <= px;
    point_if.point_y <= py;
    @(posedge clk_i);
    while (!point_if.ready) @(posedge clk_i);
    pending_q.insert(pending_q.size(), fixed ? w : map_point(px, py));
  endtask

  // Fresh settings for one random phase; only called with the pipe empty.
  task automatic random_setup();
    bit dead;
    dead = ($urandom_range(0, 11) == 0);
    calm = ($urandom_range(0, 3) == 0);
    reg_write(REG_KIND, with_junk(CfgW'($urandom_range(0, 1)), 1));
    reg_write(REG_COEF_ROW0, {pick_coef(), pick_coef()});
    reg_write(REG_COEF_ROW1, {pick_coef(), pick_coef()});
    reg_write(REG_SHIFT_X, with_junk(CfgW'(pick_shift()), ShiftW));
    reg_write(REG_SHIFT_Y, with_junk(CfgW'(pick_shift()), ShiftW));
    reg_write(REG_CLIP_WIDTH, with_junk(dead ? '0 : CfgW'(pick_clip()), ClipW));
    reg_write(REG_CLIP_HEIGHT, with_junk(dead ? '0 : CfgW'(pick_clip()), ClipW));
    if ($urandom_range(0, 7) == 0) reg_write(RegNone, CfgW'({$urandom(), $urandom()}));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned sent_rand;
    int unsigned burst;
    bit          streaming;
    sent_rand        = 0;
    streaming        = 1'b0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = REG_KIND;
    cfg_data_i       = '0;
    point_if.valid   = 1'b0;
    point_if.point_x = '0;
    point_if.point_y = '0;
    shadow_reset();
    build_plan();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: writes only land once the pipe is empty.
    foreach (plan_q[i]) begin
      if (plan_q[i].kind == STEP_WRITE) begin
        if (streaming) drain();
        streaming = 1'b0;
        reg_write(plan_q[i].idx, plan_q[i].data);
      end else begin
        send_point(plan_q[i].px, plan_q[i].py, plan_q[i].fixed, plan_q[i].want);
        streaming = 1'b1;
      end
    end
    drain();

    // Random phases, each with its own register settings.
    while (sent_rand < RandItems) begin
      random_setup();
      burst = $urandom_range(20, 90);
      for (int i = 0; i < burst; i++) begin
        send_point(pick_coord(cw_r), pick_coord(ch_r), 1'b0, '0);
        sent_rand++;
        // Occasional full stop mid-phase.
        if ($urandom_range(0, 199) == 0) drain();
      end
      drain();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (pending_q.size() != 0)
      log_fail($sformatf("%0d expected words never arrived", pending_q.size()));
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and checking
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned stall;
    mapped_pt_t  got;
    mapped_pt_t  exp_w;
    stall           = 0;
    result_if.ready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      // Sampled values are the ones from before this edge.
      if (result_if.valid && result_if.ready) begin
        got.x        = result_if.out_x;
        got.y        = result_if.out_y;
        got.clipped  = result_if.was_clipped;
        got.size_err = result_if.size_error;
        if (pending_q.size() == 0) begin
          log_fail($sformatf("unexpected word x=%0d y=%0d clip=%0b err=%0b",
                             got.x, got.y, got.clipped, got.size_err));
        end else begin
          exp_w = pending_q.pop_front();
          if (got.x !== exp_w.x || got.y !== exp_w.y ||
              got.clipped !== exp_w.clipped || got.size_err !== exp_w.size_err)
            log_fail($sformatf({"mismatch: expected x=%0d y=%0d clip=%0b err=%0b,",
                                " got x=%0d y=%0d clip=%0b err=%0b"},
                               exp_w.x, exp_w.y, exp_w.clipped, exp_w.size_err,
                               got.x, got.y, got.clipped, got.size_err));
        end
      end
      if (stall != 0) begin
        stall--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall = idle_len();
      end
      result_if.ready <= (stall == 0);
      @(posedge clk_i);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/aptc_pkg.sv
design/aptc_in_if.sv
design/aptc_out_if.sv
design/affine_point_transform_clip.sv
tb/sv/affine_point_transform_clip_tb.sv
